// File: rtl/temp_source_priority_selector_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef TEMP_SOURCE_PRIORITY_SELECTOR_DEFINES_SVH
`define TEMP_SOURCE_PRIORITY_SELECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tsps_pkg.sv
package tsps_pkg;

  localparam int NUM_SOURCES = 5;
  localparam int TEMP_W      = 16;
  localparam int SRC_W       = 3;
  localparam int AGE_W       = 16;

  // Provider indexes
  localparam logic [SRC_W-1:0] SRC_DEFAULT  = 3'd0;
  localparam logic [SRC_W-1:0] SRC_SENSOR   = 3'd1;
  localparam logic [SRC_W-1:0] SRC_MODULE   = 3'd2;
  localparam logic [SRC_W-1:0] SRC_VARIABLE = 3'd3;
  localparam logic [SRC_W-1:0] SRC_MANUAL   = 3'd4;

  // Configuration reset values
  localparam logic [AGE_W-1:0]         STALE_TIMEOUT_RST = 16'd5000;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST      = -16'sd400;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST      = 16'sd1250;
  localparam logic signed [TEMP_W-1:0] DEFAULT_TEMP_RST  = 16'sd250;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_REG    = 3'd1,
    OP_UNREG  = 3'd2,
    OP_UPDATE = 3'd3,
    OP_QUERY  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_ARG     = 2'd1,
    ST_BAD_STATE   = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_MANUAL_ENABLE    = 3'd0,
    CFG_PREFERRED_SOURCE = 3'd1,
    CFG_VARIABLE_BOUND   = 3'd2,
    CFG_STALE_TIMEOUT    = 3'd3,
    CFG_TEMP_MIN         = 3'd4,
    CFG_TEMP_MAX         = 3'd5,
    CFG_DEFAULT_TEMP     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]                opcode;
    logic [SRC_W-1:0]          source;
    logic signed [TEMP_W-1:0]  temp;
    logic                      var_ok;
    logic signed [TEMP_W-1:0]  var_temp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [TEMP_W-1:0]  cur_temp;
    logic [SRC_W-1:0]          cur_source;
    logic                      changed;
    logic signed [TEMP_W-1:0]  last_temp;
    logic [SRC_W-1:0]          last_source;
  } out_item_t;

  typedef struct packed {
    logic                      manual_enable;
    logic [1:0]                pref_source;
    logic                      variable_bound;
    logic [AGE_W-1:0]          stale_timeout;
    logic signed [TEMP_W-1:0]  temp_min;
    logic signed [TEMP_W-1:0]  temp_max;
    logic signed [TEMP_W-1:0]  default_temp;
  } cfg_t;

  // Provider table as seen after the current item is applied
  typedef struct packed {
    logic [NUM_SOURCES-1:0][TEMP_W-1:0] value;
    logic [NUM_SOURCES-1:0]             registered;
    logic [NUM_SOURCES-1:0]             active;
    logic [NUM_SOURCES-1:0]             fresh;
  } prov_view_t;

  typedef struct packed {
    status_e status;
    logic    reselect;
  } tbl_res_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] cur_temp;
    logic [SRC_W-1:0]         cur_source;
    logic                     changed;
    logic signed [TEMP_W-1:0] last_temp;
    logic [SRC_W-1:0]         last_source;
  } sel_res_t;

endpackage

// File: rtl/tsps_table.sv
module tsps_table import tsps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  output prov_view_t view_o,
  output tbl_res_t   res_o
);

  logic [NUM_SOURCES-1:0][TEMP_W-1:0] value_q, value_d;
  logic [NUM_SOURCES-1:0][AGE_W-1:0]  age_q, age_d;
  logic [NUM_SOURCES-1:0]             reg_q, reg_d;
  logic [NUM_SOURCES-1:0]             act_q, act_d;
  logic                               src_ok;
  logic                               src_reg;
  logic                               in_range;

  // Decode the item and apply its effect on the table
  always_comb begin
    value_d = value_q;
    age_d   = age_q;
    reg_d   = reg_q;
    act_d   = act_q;
    res_o   = '{status: ST_OK, reselect: 1'b0};

    src_ok   = item_i.source < SRC_W'(NUM_SOURCES);
    in_range = !(item_i.temp < cfg_i.temp_min || item_i.temp > cfg_i.temp_max);
    src_reg  = 1'b0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (item_i.source == SRC_W'(i)) src_reg = reg_q[i];
    end

    unique case (item_i.opcode)
      OP_TICK: begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
          if (age_q[i] != '1) age_d[i] = age_q[i] + AGE_W'(1);
        end
      end
      OP_REG: begin
        if (!src_ok) begin
          res_o.status = ST_BAD_ARG;
        end else begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (item_i.source == SRC_W'(i)) begin
              value_d[i] = cfg_i.default_temp;
              age_d[i]   = '0;
              reg_d[i]   = 1'b1;
              act_d[i]   = 1'b0;
            end
          end
        end
      end
      OP_UNREG: begin
        if (!src_ok) begin
          res_o.status = ST_BAD_ARG;
        end else if (item_i.source == SRC_DEFAULT) begin
          res_o.status = ST_UNSUPPORTED;
        end else begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (item_i.source == SRC_W'(i)) begin
              reg_d[i] = 1'b0;
              act_d[i] = 1'b0;
            end
          end
          res_o.reselect = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (!src_ok || !in_range) begin
          res_o.status = ST_BAD_ARG;
        end else if (!src_reg) begin
          res_o.status = ST_BAD_STATE;
        end else begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (item_i.source == SRC_W'(i)) begin
              value_d[i] = item_i.temp;
              age_d[i]   = '0;
              act_d[i]   = 1'b1;
            end
          end
          res_o.reselect = 1'b1;
        end
      end
      OP_QUERY: begin
        res_o.reselect = 1'b1;
      end
      default: begin
        res_o.status = ST_UNSUPPORTED;
      end
    endcase
  end

  // Present the updated table to the selector
  always_comb begin
    view_o.value      = value_d;
    view_o.registered = reg_d;
    view_o.active     = act_d;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      view_o.fresh[i] = age_d[i] < cfg_i.stale_timeout;
    end
  end

  // Hold the table; advance on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        value_q[i] <= DEFAULT_TEMP_RST;
        age_q[i]   <= '0;
      end
      reg_q <= NUM_SOURCES'(1) << SRC_DEFAULT;
      act_q <= NUM_SOURCES'(1) << SRC_DEFAULT;
    end else if (en_i) begin
      value_q <= value_d;
      age_q   <= age_d;
      reg_q   <= reg_d;
      act_q   <= act_d;
    end
  end

endmodule

// File: rtl/tsps_select.sv
module tsps_select import tsps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     reselect_i,
  input  cfg_t                     cfg_i,
  input  prov_view_t               view_i,
  input  logic                     var_ok_i,
  input  logic signed [TEMP_W-1:0] var_temp_i,
  output sel_res_t                 res_o
);

  logic signed [TEMP_W-1:0] sel_temp_q, sel_temp_d;
  logic [SRC_W-1:0]         sel_src_q, sel_src_d;
  logic signed [TEMP_W-1:0] cand_temp;
  logic [SRC_W-1:0]         cand_src;
  logic signed [TEMP_W-1:0] var_val;
  logic                     var_v;
  logic                     sensor_v;
  logic                     module_v;
  logic                     diff;

  // Validity of each candidate
  always_comb begin
    var_v    = cfg_i.variable_bound && var_ok_i;
    var_val  = (var_temp_i < cfg_i.temp_min || var_temp_i > cfg_i.temp_max) ?
               cfg_i.default_temp : var_temp_i;
    sensor_v = view_i.registered[SRC_SENSOR] && view_i.active[SRC_SENSOR] &&
               view_i.fresh[SRC_SENSOR];
    module_v = view_i.registered[SRC_MODULE] && view_i.active[SRC_MODULE] &&
               view_i.fresh[SRC_MODULE];
  end

  // Pick the winner by fixed priority
  always_comb begin
    priority if (cfg_i.manual_enable && view_i.registered[SRC_MANUAL]) begin
      cand_src  = SRC_MANUAL;
      cand_temp = view_i.value[SRC_MANUAL];
    end else if (cfg_i.pref_source == SRC_VARIABLE[1:0] && var_v) begin
      cand_src  = SRC_VARIABLE;
      cand_temp = var_val;
    end else if (cfg_i.pref_source == SRC_MODULE[1:0] && module_v) begin
      cand_src  = SRC_MODULE;
      cand_temp = view_i.value[SRC_MODULE];
    end else if (cfg_i.pref_source == SRC_SENSOR[1:0] && sensor_v) begin
      cand_src  = SRC_SENSOR;
      cand_temp = view_i.value[SRC_SENSOR];
    end else if (var_v) begin
      cand_src  = SRC_VARIABLE;
      cand_temp = var_val;
    end else if (module_v) begin
      cand_src  = SRC_MODULE;
      cand_temp = view_i.value[SRC_MODULE];
    end else if (sensor_v) begin
      cand_src  = SRC_SENSOR;
      cand_temp = view_i.value[SRC_SENSOR];
    end else begin
      cand_src  = SRC_DEFAULT;
      cand_temp = cfg_i.default_temp;
    end
  end

  // Detect a change and form the result
  always_comb begin
    diff       = reselect_i && (cand_temp != sel_temp_q || cand_src != sel_src_q);
    sel_temp_d = diff ? cand_temp : sel_temp_q;
    sel_src_d  = diff ? cand_src : sel_src_q;

    res_o.cur_temp    = sel_temp_d;
    res_o.cur_source  = sel_src_d;
    res_o.changed     = diff;
    res_o.last_temp   = sel_temp_q;
    res_o.last_source = sel_src_q;
    if (!diff) begin
      res_o.last_temp   = sel_temp_d;
      res_o.last_source = sel_src_d;
    end
  end

  // Hold the current selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_temp_q <= DEFAULT_TEMP_RST;
      sel_src_q  <= SRC_DEFAULT;
    end else if (en_i) begin
      sel_temp_q <= sel_temp_d;
      sel_src_q  <= sel_src_d;
    end
  end

endmodule

// File: rtl/temp_source_priority_selector.sv
// Temperature source selector: keeps five providers (default, sensor, module,
// bound variable, manual) and picks the current temperature by fixed priority.
// One item is taken every clock cycle when in_stall_o is low; each item passes
// an input register, table update and priority selection, and a result register,
// where its result is held until the output is not stalled. The result register
// lets the next item enter while a result waits.
// Configuration writes are registered and take effect on the next item;
// there is no clearing pass after reset.
`include "temp_source_priority_selector_defines.svh"

module temp_source_priority_selector import tsps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [TEMP_W-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  in_item_t   in_q;
  logic       in_valid_q;
  out_item_t  out_q, out_d;
  logic       out_valid_q;
  logic       advance;
  logic       accept;
  prov_view_t view;
  tbl_res_t   tbl_res;
  sel_res_t   sel_res;

  // Handshake: move the held item on when the result register is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manual_enable  <= 1'b0;
      cfg_q.pref_source    <= 2'd0;
      cfg_q.variable_bound <= 1'b0;
      cfg_q.stale_timeout  <= STALE_TIMEOUT_RST;
      cfg_q.temp_min       <= TEMP_MIN_RST;
      cfg_q.temp_max       <= TEMP_MAX_RST;
      cfg_q.default_temp   <= DEFAULT_TEMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MANUAL_ENABLE:    cfg_q.manual_enable  <= cfg_wdata_i[0];
        CFG_PREFERRED_SOURCE: cfg_q.pref_source    <= cfg_wdata_i[1:0];
        CFG_VARIABLE_BOUND:   cfg_q.variable_bound <= cfg_wdata_i[0];
        CFG_STALE_TIMEOUT:    cfg_q.stale_timeout  <= cfg_wdata_i;
        CFG_TEMP_MIN:         cfg_q.temp_min       <= cfg_wdata_i;
        CFG_TEMP_MAX:         cfg_q.temp_max       <= cfg_wdata_i;
        CFG_DEFAULT_TEMP:     cfg_q.default_temp   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  tsps_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .view_o (view),
    .res_o  (tbl_res)
  );

  tsps_select u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .reselect_i (tbl_res.reselect),
    .cfg_i      (cfg_q),
    .view_i     (view),
    .var_ok_i   (in_q.var_ok),
    .var_temp_i (in_q.var_temp),
    .res_o      (sel_res)
  );

  // Assemble the result item
  always_comb begin
    out_d.status      = tbl_res.status;
    out_d.cur_temp    = sel_res.cur_temp;
    out_d.cur_source  = sel_res.cur_source;
    out_d.changed     = sel_res.changed;
    out_d.last_temp   = sel_res.last_temp;
    out_d.last_source = sel_res.last_source;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TSPS_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(in_q),
                    "held item lost")
  `TSPS_ASSERT_NEXT(a_no_resel_no_chg, advance && !tbl_res.reselect, !out_q.changed,
                    "change without reselect")
  `TSPS_ASSERT_NOW(a_same_last, out_valid_o && !out_item_o.changed,
                   out_item_o.last_temp == out_item_o.cur_temp &&
                   out_item_o.last_source == out_item_o.cur_source,
                   "last selection differs without change")
  `TSPS_ASSERT_NOW(a_chg_differs, out_valid_o && out_item_o.changed,
                   out_item_o.last_temp != out_item_o.cur_temp ||
                   out_item_o.last_source != out_item_o.cur_source,
                   "change flagged but selection equal")
  `TSPS_ASSERT_NOW(a_err_no_chg, out_valid_o && out_item_o.status != ST_OK,
                   !out_item_o.changed, "rejected item changed selection")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tsps_pkg::*;

  // Codes outside the defined opcode and provider ranges
  localparam logic [2:0] CODE_MAX   = 3'd7;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] SRC_BAD_LO = 3'd5;

  localparam int IDLE_MAX    = 7;
  localparam int WDOG_LIMIT  = 2000;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 145;
  localparam int AGE_TICKS   = 24;
  localparam logic [AGE_W-1:0] STALE_TICKS = 16'd20;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;
  logic              cfg_we_i    = 1'b0;
  logic [2:0]        cfg_idx_i   = '0;
  logic [TEMP_W-1:0] cfg_wdata_i = '0;

  temp_source_priority_selector u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow configuration
  logic                     c_manual;
  logic [1:0]               c_pref;
  logic                     c_vbound;
  logic [AGE_W-1:0]         c_timeout;
  logic signed [TEMP_W-1:0] c_tmin;
  logic signed [TEMP_W-1:0] c_tmax;
  logic signed [TEMP_W-1:0] c_tdef;

  // Shadow provider table and held selection
  logic signed [TEMP_W-1:0] tbl_val [NUM_SOURCES];
  logic [AGE_W-1:0]         tbl_age [NUM_SOURCES];
  logic                     tbl_reg [NUM_SOURCES];
  logic                     tbl_act [NUM_SOURCES];
  logic signed [TEMP_W-1:0] held_temp;
  logic [SRC_W-1:0]         held_src;

  out_item_t pending_sel_q[$];
  int        err_cnt     = 0;
  int        gap_max     = 0;
  int        stall_max   = 0;
  int        rx_hold     = 0;
  int        idle_cycles = 0;

  function automatic void table_reset();
    c_manual  = 1'b0;
    c_pref    = '0;
    c_vbound  = 1'b0;
    c_timeout = STALE_TIMEOUT_RST;
    c_tmin    = TEMP_MIN_RST;
    c_tmax    = TEMP_MAX_RST;
    c_tdef    = DEFAULT_TEMP_RST;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      tbl_val[i] = DEFAULT_TEMP_RST;
      tbl_age[i] = '0;
      tbl_reg[i] = (i == SRC_DEFAULT);
      tbl_act[i] = (i == SRC_DEFAULT);
    end
    held_temp = DEFAULT_TEMP_RST;
    held_src  = SRC_DEFAULT;
  endfunction

  function automatic void cfg_shadow(cfg_reg_e idx, logic [TEMP_W-1:0] val);
    case (idx)
      CFG_MANUAL_ENABLE:    c_manual  = val[0];
      CFG_PREFERRED_SOURCE: c_pref    = val[1:0];
      CFG_VARIABLE_BOUND:   c_vbound  = val[0];
      CFG_STALE_TIMEOUT:    c_timeout = val;
      CFG_TEMP_MIN:         c_tmin    = val;
      CFG_TEMP_MAX:         c_tmax    = val;
      CFG_DEFAULT_TEMP:     c_tdef    = val;
      default: ;
    endcase
  endfunction

  // Sensor or module entry usable: registered, active and younger than timeout
  function automatic bit entry_live(logic [SRC_W-1:0] s);
    return tbl_reg[s] && tbl_act[s] && (tbl_age[s] < c_timeout);
  endfunction

  // Walk the priority order and return the winning temperature and source
  function automatic void pick_source(input bit vok, input logic signed [TEMP_W-1:0] vt,
                                      output logic signed [TEMP_W-1:0] t,
                                      output logic [SRC_W-1:0] s);
    bit                       var_live;
    bit                       found;
    logic signed [TEMP_W-1:0] var_t;
    logic [SRC_W-1:0]         pref;
    var_live = c_vbound && vok;
    var_t    = (vt < c_tmin || vt > c_tmax) ? c_tdef : vt;
    pref     = {1'b0, c_pref};
    s        = SRC_DEFAULT;
    t        = c_tdef;
    found    = 1'b0;
    if (c_manual && tbl_reg[SRC_MANUAL]) begin
      s = SRC_MANUAL; t = tbl_val[SRC_MANUAL]; found = 1'b1;
    end
    if (!found && pref == SRC_VARIABLE && var_live) begin
      s = SRC_VARIABLE; t = var_t; found = 1'b1;
    end else if (!found && pref != SRC_DEFAULT && pref != SRC_VARIABLE && entry_live(pref)) begin
      s = pref; t = tbl_val[pref]; found = 1'b1;
    end
    if (!found && var_live) begin
      s = SRC_VARIABLE; t = var_t; found = 1'b1;
    end
    if (!found && entry_live(SRC_MODULE)) begin
      s = SRC_MODULE; t = tbl_val[SRC_MODULE]; found = 1'b1;
    end
    if (!found && entry_live(SRC_SENSOR)) begin
      s = SRC_SENSOR; t = tbl_val[SRC_SENSOR];
    end
  endfunction

  // Apply one command to the shadow table and return the selection it yields
  function automatic out_item_t select_step(in_item_t it);
    out_item_t                r;
    bit                       resel;
    logic [SRC_W-1:0]         s;
    logic signed [TEMP_W-1:0] t;
    logic [SRC_W-1:0]         ns;
    logic signed [TEMP_W-1:0] nt;
    r      = '0;
    r.status = ST_OK;
    resel  = 1'b0;
    s      = it.source;
    t      = it.temp;
    case (it.opcode)
      OP_TICK: begin
        for (int i = 0; i < NUM_SOURCES; i++)
          if (tbl_age[i] != '1) tbl_age[i] = tbl_age[i] + 1'b1;
      end
      OP_REG: begin
        if (s > SRC_MANUAL) r.status = ST_BAD_ARG;
        else begin
          tbl_val[s] = c_tdef;
          tbl_age[s] = '0;
          tbl_reg[s] = 1'b1;
          tbl_act[s] = 1'b0;
        end
      end
      OP_UNREG: begin
        if (s > SRC_MANUAL) r.status = ST_BAD_ARG;
        else if (s == SRC_DEFAULT) r.status = ST_UNSUPPORTED;
        else begin
          tbl_reg[s] = 1'b0;
          tbl_act[s] = 1'b0;
          resel = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (s > SRC_MANUAL) r.status = ST_BAD_ARG;
        else if (t < c_tmin || t > c_tmax) r.status = ST_BAD_ARG;
        else if (!tbl_reg[s]) r.status = ST_BAD_STATE;
        else begin
          tbl_val[s] = t;
          tbl_age[s] = '0;
          tbl_act[s] = 1'b1;
          resel = 1'b1;
        end
      end
      OP_QUERY: resel = 1'b1;
      default: r.status = ST_UNSUPPORTED;
    endcase
    r.last_temp   = held_temp;
    r.last_source = held_src;
    if (resel) begin
      pick_source(it.var_ok, it.var_temp, nt, ns);
      if (nt != held_temp || ns != held_src) begin
        r.changed = 1'b1;
        held_temp = nt;
        held_src  = ns;
      end
    end
    r.cur_temp   = held_temp;
    r.cur_source = held_src;
    return r;
  endfunction

  function automatic in_item_t pack_cmd(logic [2:0] op, logic [SRC_W-1:0] src,
                                        logic [TEMP_W-1:0] t, logic vok,
                                        logic [TEMP_W-1:0] vt);
    in_item_t it;
    it.opcode   = op;
    it.source   = src;
    it.temp     = t;
    it.var_ok   = vok;
    it.var_temp = vt;
    return it;
  endfunction

  // Mostly in-range temperatures, some at or just beyond the limits, the rest anywhere
  function automatic logic [TEMP_W-1:0] rand_temp();
    int lo;
    int hi;
    int r;
    lo = c_tmin;
    hi = c_tmax;
    r  = $urandom_range(0, 9);
    if (r < 5 && lo <= hi) return TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
    if (r < 7) begin
      case ($urandom_range(0, 3))
        0: return c_tmin;
        1: return c_tmax;
        2: return c_tmin - 1'b1;
        default: return c_tmax + 1'b1;
      endcase
    end
    return TEMP_W'($urandom);
  endfunction

  function automatic in_item_t random_cmd();
    int               r;
    logic [2:0]       op;
    logic [SRC_W-1:0] src;
    r = $urandom_range(0, 99);
    if (r < 25)      op = OP_TICK;
    else if (r < 35) op = OP_REG;
    else if (r < 43) op = OP_UNREG;
    else if (r < 75) op = OP_UPDATE;
    else if (r < 97) op = OP_QUERY;
    else             op = 3'($urandom_range(OP_RSVD_LO, CODE_MAX));
    if ($urandom_range(0, 99) < 8) src = SRC_W'($urandom_range(SRC_BAD_LO, CODE_MAX));
    else                           src = SRC_W'($urandom_range(SRC_DEFAULT, SRC_MANUAL));
    return pack_cmd(op, src, rand_temp(), 1'($urandom_range(0, 1)), rand_temp());
  endfunction

  // Send one item after a random gap and record its predicted result
  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_sel_q.push_back(select_step(it));
  endtask

  // Drop valid and wait until every result has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_sel_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [TEMP_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    cfg_shadow(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic man, logic [1:0] pref, logic vb, logic [AGE_W-1:0] tmo,
                           logic [TEMP_W-1:0] lo, logic [TEMP_W-1:0] hi,
                           logic [TEMP_W-1:0] dflt);
    cfg_write(CFG_MANUAL_ENABLE, TEMP_W'(man));
    cfg_write(CFG_PREFERRED_SOURCE, TEMP_W'(pref));
    cfg_write(CFG_VARIABLE_BOUND, TEMP_W'(vb));
    cfg_write(CFG_STALE_TIMEOUT, tmo);
    cfg_write(CFG_TEMP_MIN, lo);
    cfg_write(CFG_TEMP_MAX, hi);
    cfg_write(CFG_DEFAULT_TEMP, dflt);
  endtask

  // Table commands and every error status, starting from reset values
  task automatic test_table_ops();
    gap_max   = IDLE_MAX;
    stall_max = IDLE_MAX;
    send_item(pack_cmd(OP_TICK, SRC_DEFAULT, 0, 1'b0, 0));
    send_item(pack_cmd(OP_REG, SRC_SENSOR, 0, 1'b0, 0));
    send_item(pack_cmd(OP_UPDATE, SRC_SENSOR, 1250, 1'b0, 0));
    send_item(pack_cmd(OP_UPDATE, SRC_SENSOR, -401, 1'b0, 0));
    send_item(pack_cmd(OP_UPDATE, SRC_MODULE, 0, 1'b0, 0));
    send_item(pack_cmd(OP_REG, CODE_MAX, 0, 1'b0, 0));
    send_item(pack_cmd(OP_UNREG, SRC_DEFAULT, 0, 1'b0, 0));
    send_item(pack_cmd(CODE_MAX, SRC_SENSOR, 0, 1'b0, 0));
    send_item(pack_cmd(OP_UNREG, SRC_SENSOR, 0, 1'b0, 0));
    send_item(pack_cmd(OP_REG, SRC_DEFAULT, 0, 1'b0, 0));
  endtask

  // Priority order: module over sensor, preferred source, variable, manual
  task automatic test_priority();
    send_item(pack_cmd(OP_REG, SRC_MODULE, 0, 1'b0, 0));
    send_item(pack_cmd(OP_UPDATE, SRC_MODULE, 300, 1'b0, 0));
    send_item(pack_cmd(OP_REG, SRC_SENSOR, 0, 1'b0, 0));
    send_item(pack_cmd(OP_UPDATE, SRC_SENSOR, -400, 1'b0, 0));
    cfg_write(CFG_PREFERRED_SOURCE, TEMP_W'(SRC_SENSOR));
    send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b1, 555));
    cfg_write(CFG_VARIABLE_BOUND, 1);
    cfg_write(CFG_PREFERRED_SOURCE, TEMP_W'(SRC_VARIABLE));
    send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b1, 555));
    // variable reading outside the valid window falls back to the default value
    send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b1, 2000));
    send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b0, 555));
    send_item(pack_cmd(OP_REG, SRC_MANUAL, 0, 1'b0, 0));
    cfg_write(CFG_MANUAL_ENABLE, 1);
    send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b1, 555));
    send_item(pack_cmd(OP_UPDATE, SRC_MANUAL, 777, 1'b1, 555));
  endtask

  // Inverted window, full-scale limits, zero and one-tick timeouts
  task automatic test_config_edges();
    write_all(1'b0, 2'(SRC_VARIABLE), 1'b1, STALE_TIMEOUT_RST, 100, -100, DEFAULT_TEMP_RST);
    send_item(pack_cmd(OP_UPDATE, SRC_SENSOR, 0, 1'b1, 0));
    send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b1, 0));
    write_all(1'b0, 2'(SRC_DEFAULT), 1'b0, 0, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(pack_cmd(OP_UPDATE, SRC_MODULE, 16'h8000, 1'b0, 16'h7FFF));
    send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b1, 16'h7FFF));
    cfg_write(CFG_STALE_TIMEOUT, 1);
    cfg_write(CFG_DEFAULT_TEMP, 16'h7FFF);
    send_item(pack_cmd(OP_UPDATE, SRC_SENSOR, 16'h7FFF, 1'b0, 0));
    send_item(pack_cmd(OP_TICK, SRC_DEFAULT, 0, 1'b0, 0));
    send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b0, 0));
  endtask

  // Age a fresh sensor tick by tick past a short timeout and watch it drop out
  task automatic test_stale_age();
    write_all(1'b0, 2'(SRC_SENSOR), 1'b0, STALE_TICKS, TEMP_MIN_RST, TEMP_MAX_RST,
              DEFAULT_TEMP_RST);
    gap_max   = 0;
    stall_max = 0;
    send_item(pack_cmd(OP_REG, SRC_SENSOR, 0, 1'b0, 0));
    send_item(pack_cmd(OP_UPDATE, SRC_SENSOR, 100, 1'b0, 0));
    repeat (AGE_TICKS) begin
      send_item(pack_cmd(OP_TICK, SRC_DEFAULT, 0, 1'b0, 0));
      send_item(pack_cmd(OP_QUERY, SRC_DEFAULT, 0, 1'b0, 0));
    end
  endtask

  // Random command streams under a series of register settings
  task automatic test_random_mix();
    int mode;
    for (int k = 0; k < PHASES; k++) begin
      case (k)
        0: write_all(1'b0, 2'(SRC_DEFAULT), 1'b1, 12, -400, 1250, 250);
        1: write_all(1'b1, 2'(SRC_MODULE), 1'b1, 6, -1000, 1000, 0);
        2: write_all(1'b0, 2'(SRC_SENSOR), 1'b0, 1, -400, 1250, -5);
        3: write_all(1'b0, 2'(SRC_VARIABLE), 1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        4: write_all(1'b1, 2'(SRC_DEFAULT), 1'b1, 30, 500, -500, 16'h8000);
        default: begin
          if ($urandom_range(0, 3) != 0)
            write_all(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), AGE_W'($urandom_range(1, 40)),
                      TEMP_W'(-int'($urandom_range(0, 600))),
                      TEMP_W'($urandom_range(0, 1500)), TEMP_W'($urandom));
          else
            write_all(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), AGE_W'($urandom_range(1, 65535)),
                      TEMP_W'($urandom), TEMP_W'($urandom), TEMP_W'($urandom));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // switch between idle-free stretches and random gaps on either side
        if (n % 30 == 0) begin
          mode      = $urandom_range(0, 3);
          gap_max   = mode[0] ? IDLE_MAX : 0;
          stall_max = mode[1] ? IDLE_MAX : 0;
        end
        send_item(random_cmd());
      end
    end
  endtask

  // Hold the output stall for a random number of cycles after each result
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [TEMP_W-1:0] want,
                                      logic [TEMP_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Compare each accepted result with the oldest predicted selection
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rx_hold = $urandom_range(0, stall_max);
      if (pending_sel_q.size() == 0) begin
        $error("result with nothing pending: %h", out_item_o);
        err_cnt++;
      end else begin
        want = pending_sel_q.pop_front();
        check_field("status", want.status, out_item_o.status);
        check_field("cur_temp", want.cur_temp, out_item_o.cur_temp);
        check_field("cur_source", want.cur_source, out_item_o.cur_source);
        check_field("changed", want.changed, out_item_o.changed);
        check_field("last_temp", want.last_temp, out_item_o.last_temp);
        check_field("last_source", want.last_source, out_item_o.last_source);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else if (idle_cycles >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    table_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_table_ops();
    test_priority();
    test_config_edges();
    test_stale_age();
    test_random_mix();
    settle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending_sel_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
